/* sv/pid_pkg.sv */
// Shared widths, codes and saturation helpers for the PID step unit.
`default_nettype none

package pid_pkg;

  localparam int DATA_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int MAG_W     = 33;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-DATA_W:0] upper;
    logic                   fits;
    upper = v[PROD_W-1:DATA_W-1];
    fits  = (&upper) | ~(|upper);
    if (fits) begin
      sat32 = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      sat32 = S32_MIN;
    end else begin
      sat32 = S32_MAX;
    end
  endfunction

  // Sign-extend a 32-bit value to the product width.
  function automatic logic signed [PROD_W-1:0] sext_prod(input logic signed [DATA_W-1:0] v);
    sext_prod = {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

/* sv/pid_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module pid_mul (
  input  wire logic                                clk,
  input  wire logic signed [pid_pkg::MUL_W-1:0]    op_a,
  input  wire logic signed [pid_pkg::MUL_W-1:0]    op_b,
  output logic signed      [pid_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

/* sv/pid_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none

module pid_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic [pid_pkg::MAG_W+FRAC_BITS-1:0]     dividend,
  input  wire logic [pid_pkg::DATA_W-1:0]              divisor,
  output logic [pid_pkg::MAG_W+FRAC_BITS-1:0]          quotient,
  output pid_pkg::div_status_t                         status
);

  localparam int NUM_W = pid_pkg::MAG_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DW    = pid_pkg::DATA_W;

  logic [NUM_W-1:0] quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    divisor_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DW:0]      rem_sh;
  logic [DW+1:0]    trial;
  logic             ge;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, divisor_r};
  assign ge     = ~trial[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r     <= dividend;
        rem_r     <= '0;
        divisor_r <= divisor;
        cnt_r     <= CNT_W'(NUM_W);
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], ge};
        rem_r <= ge ? trial[DW-1:0] : rem_sh[DW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

/* sv/pid_step_with_integrator_clamp_unit.sv */
// PID step unit: one controller update per input transfer with a clamped integrator.
//
// Input channel: in_valid / in_stall carry error, time step and hold flag. A transfer
// takes place when in_valid is high and in_stall is low. Result channel: out_valid /
// out_stall carry the drive value, clamp status and the invalid-step flag, one result
// per input transfer, in order. The configuration port writes gains, the limit and the
// enable bit through cfg_wr_en, cfg_index and cfg_data; the user must write only while
// the unit is idle, as the block itself does not enforce it.
// An item with a zero time step goes straight to result delivery. The first item
// after reset skips the divider and takes a zero derivative; every later item waits
// for the divider, which retires one quotient bit per cycle. Then a single multiplier
// is used in turn for error*dt and *ki (if enabled, not held), then *kp and *kd.
// in_stall is high while an item is in progress. The result sits in an output register,
// so a new item can be taken while it waits; an item that finishes while the receiver
// still stalls waits for the register to empty before committing.
// Reset (synchronous, rst_n low) clears all gains, the integral, the stored error and
// output, and marks the next item as the first sample.
`default_nettype none

module pid_step_with_integrator_clamp_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [pid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pid_pkg::DATA_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [pid_pkg::DATA_W-1:0]    in_error_value,
  input  wire logic [pid_pkg::DATA_W-1:0]           in_time_step,
  input  wire logic                                 in_hold_integral,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [pid_pkg::DATA_W-1:0]         out_drive_value,
  output logic [1:0]                                out_clamp_status,
  output logic                                      out_step_invalid
);

  localparam int DW     = pid_pkg::DATA_W;
  localparam int PW     = pid_pkg::PROD_W;
  localparam int MW     = pid_pkg::MUL_W;
  localparam int NUM_W  = pid_pkg::MAG_W + FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_INTEG,
    S_EDT_MUL,
    S_EDT_SAT,
    S_KI_MUL,
    S_KI_ADD,
    S_CLAMP,
    S_KP_MUL,
    S_KP_ADD,
    S_KD_ADD,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic signed [DW-1:0]                kp_r, ki_r, kd_r;
  logic [pid_pkg::LIMIT_W-1:0]         limit_r;
  logic                                enable_r;

  // Controller state
  logic signed [DW-1:0] last_error_r, last_output_r, integral_r;
  logic                 first_r;
  logic [1:0]           clamp_r;

  // Working registers of the item in progress
  logic signed [DW-1:0] err_r, edt_r, diff_r;
  logic [DW-1:0]        dt_r;
  logic                 hold_r, neg_r, invalid_r;
  logic signed [PW-1:0] acc_r;

  // Output register
  logic                 out_valid_r, out_invalid_r;
  logic signed [DW-1:0] out_drive_r;
  logic [1:0]           out_clamp_r;

  logic                 in_xfer;
  logic                 out_free;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_shift;
  logic signed [MW-1:0] delta;
  logic [pid_pkg::MAG_W-1:0] delta_mag;
  logic [NUM_W-1:0]     div_quo;
  pid_pkg::div_status_t div_stat;
  logic                 div_start;
  logic signed [PW-1:0] lim_ext;
  logic signed [PW-1:0] neg_lim;
  logic signed [PW-1:0] final_sum;
  logic                 quo_big;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign delta     = MW'(in_error_value) - MW'(last_error_r);
  assign delta_mag = delta[MW-1] ? pid_pkg::MAG_W'(-delta) : pid_pkg::MAG_W'(delta);
  assign div_start = in_xfer && (in_time_step != '0) && !first_r;

  assign prod_shift = prod >>> FRAC_BITS;
  assign lim_ext    = PW'(limit_r);
  assign neg_lim    = -lim_ext;
  assign final_sum  = acc_r + pid_pkg::sext_prod(integral_r);
  assign quo_big    = |div_quo[NUM_W-1:DW-1];

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      S_EDT_MUL: begin
        mul_a = MW'(err_r);
        mul_b = $signed({1'b0, dt_r});
      end
      S_KI_MUL: begin
        mul_a = MW'(edt_r);
        mul_b = MW'(ki_r);
      end
      S_KP_MUL: begin
        mul_a = MW'(err_r);
        mul_b = MW'(kp_r);
      end
      S_KP_ADD: begin
        mul_a = MW'(diff_r);
        mul_b = MW'(kd_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pid_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  pid_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({delta_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (in_time_step),
    .quotient (div_quo),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      limit_r  <= '0;
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pid_pkg::REG_KP:     kp_r     <= cfg_data;
        pid_pkg::REG_KI:     ki_r     <= cfg_data;
        pid_pkg::REG_KD:     kd_r     <= cfg_data;
        pid_pkg::REG_LIMIT:  limit_r  <= cfg_data[pid_pkg::LIMIT_W-1:0];
        pid_pkg::REG_ENABLE: enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      last_error_r  <= '0;
      last_output_r <= '0;
      integral_r    <= '0;
      first_r       <= 1'b1;
      clamp_r       <= pid_pkg::CLAMP_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            err_r  <= in_error_value;
            dt_r   <= in_time_step;
            hold_r <= in_hold_integral;
            neg_r  <= delta[MW-1];
            if (in_time_step == '0) begin
              invalid_r <= 1'b1;
              state_r   <= S_DONE;
            end else if (first_r) begin
              invalid_r <= 1'b0;
              first_r   <= 1'b0;
              diff_r    <= '0;
              state_r   <= S_INTEG;
            end else begin
              invalid_r <= 1'b0;
              state_r   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            // Truncated quotient, saturated to 32 bits with the sign of the difference.
            if (neg_r) begin
              diff_r <= quo_big ? pid_pkg::S32_MIN : -$signed({1'b0, div_quo[DW-2:0]});
            end else begin
              diff_r <= quo_big ? pid_pkg::S32_MAX : $signed({1'b0, div_quo[DW-2:0]});
            end
            state_r <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (!enable_r) begin
            integral_r <= '0;
            state_r    <= S_KP_MUL;
          end else if (hold_r) begin
            state_r <= S_KP_MUL;
          end else begin
            state_r <= S_EDT_MUL;
          end
        end
        S_EDT_MUL: begin
          state_r <= S_EDT_SAT;
        end
        S_EDT_SAT: begin
          edt_r   <= pid_pkg::sat32(prod_shift);
          state_r <= S_KI_MUL;
        end
        S_KI_MUL: begin
          state_r <= S_KI_ADD;
        end
        S_KI_ADD: begin
          acc_r   <= pid_pkg::sext_prod(integral_r) + prod_shift;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if (acc_r > lim_ext) begin
            integral_r <= lim_ext[DW-1:0];
            clamp_r    <= pid_pkg::CLAMP_HIGH;
          end else if (acc_r < neg_lim) begin
            integral_r <= neg_lim[DW-1:0];
            clamp_r    <= pid_pkg::CLAMP_LOW;
          end else begin
            integral_r <= acc_r[DW-1:0];
            clamp_r    <= pid_pkg::CLAMP_NONE;
          end
          state_r <= S_KP_MUL;
        end
        S_KP_MUL: begin
          state_r <= S_KP_ADD;
        end
        S_KP_ADD: begin
          acc_r   <= prod_shift;
          state_r <= S_KD_ADD;
        end
        S_KD_ADD: begin
          acc_r   <= acc_r + prod_shift;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_clamp_r   <= clamp_r;
            out_invalid_r <= invalid_r;
            if (invalid_r) begin
              out_drive_r <= last_output_r;
            end else begin
              out_drive_r   <= pid_pkg::sat32(final_sum);
              last_output_r <= pid_pkg::sat32(final_sum);
              last_error_r  <= err_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_value  = out_drive_r;
  assign out_clamp_status = out_clamp_r;
  assign out_step_invalid = out_invalid_r;

  // A zero time step goes straight to result delivery.
  a_zero_dt_skips : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_time_step == '0) |=> (state_r == S_DONE))
    else $error("zero time step did not go straight to result delivery");

  // While waiting on the divider it must be running or just finished.
  a_div_active : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // After a clamp step the integral lies within the limit.
  a_integral_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP) |=>
      (pid_pkg::sext_prod(integral_r) <= lim_ext && pid_pkg::sext_prod(integral_r) >= neg_lim))
    else $error("integral outside its limit after clamping");

  // A disabled integrator leaves a zero integral.
  a_disabled_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INTEG && !enable_r) |=> (integral_r == '0))
    else $error("disabled integrator did not clear the integral");

endmodule

`default_nettype wire
